[hdl/gray_tone_quantizer_macros.svh]
// Assertion macros shared by the gray tone quantizer modules.
`ifndef GRAY_TONE_QUANTIZER_MACROS_SVH
`define GRAY_TONE_QUANTIZER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define GTQ_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define GTQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define GTQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/gtq_pkg.sv]
// Shared types and constants of the gray tone quantizer.
`default_nettype none
package gtq_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;

    // Register word index of tone_count on the configuration port.
    localparam logic REG_TONE_COUNT = 1'b0;

    localparam logic [8:0] TONE_COUNT_RESET = 9'd256;
    localparam logic [7:0] TONE_MIN_RESET   = 8'd255;
    localparam logic [7:0] TONE_MAX_RESET   = 8'd0;

    // Divider: 17-bit dividend, 10-bit divisor, quotient known to fit 9 bits.
    localparam int DVD_W     = 17;
    localparam int DVS_W     = 10;
    localparam int DIV_STEPS = 9;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Queue depth between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified map word handed from front to back.
    typedef struct packed {
        logic       quant;   // pixel is requantized, else it passes unchanged
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] d;       // saturated offset of c0 above the range minimum
        logic [8:0] r;       // range size, 2..256 when quant is set
        logic [7:0] n;       // tone count, below r when quant is set
        logic [7:0] tmin;
    } gtq_job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL1,
        B_START1,
        B_DIV1,
        B_MUL2,
        B_START2,
        B_DIV2,
        B_DONE
    } gtq_back_state_t;

endpackage
`default_nettype wire

[hdl/gtq_front.sv]
// Front end: accepts words, tracks the tone range and classifies map words.
`default_nettype none
module gtq_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic [1:0]        s_op,
    input  wire logic [7:0]        s_c0,
    input  wire logic [7:0]        s_c1,
    input  wire logic [7:0]        s_c2,
    output logic                   s_ready,
    input  wire logic [8:0]        tone_count,
    input  wire logic              q_full,
    output logic                   q_push,
    output gtq_pkg::gtq_job_t      q_job
);
    import gtq_pkg::*;

    logic [7:0] tmin_reg, tmin_next;
    logic [7:0] tmax_reg, tmax_next;
    logic       accept;
    logic       rng_ok;
    logic [8:0] rng;
    logic       quant;
    logic [7:0] d;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (s_op == OP_MAP);

    always_comb begin
        tmin_next = tmin_reg;
        tmax_next = tmax_reg;
        if (accept) begin
            unique case (s_op)
                OP_CLEAR: begin
                    tmin_next = TONE_MIN_RESET;
                    tmax_next = TONE_MAX_RESET;
                end
                OP_SCAN: begin
                    if (s_c0 > tmax_reg) tmax_next = s_c0;
                    if (s_c0 < tmin_reg) tmin_next = s_c0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmin_reg <= TONE_MIN_RESET;
            tmax_reg <= TONE_MAX_RESET;
        end else begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
    end

    // An empty range wraps here, but quant is then forced low.
    assign rng_ok = (tmax_reg >= tmin_reg);
    assign rng    = {1'b0, tmax_reg} - {1'b0, tmin_reg} + 9'd1;
    assign quant  = rng_ok && (tone_count != 9'd0) && (tone_count < rng);

    // Gray levels outside the scanned range clamp to its ends.
    always_comb begin
        priority if (s_c0 < tmin_reg) begin
            d = 8'd0;
        end else if (s_c0 > tmax_reg) begin
            d = rng[7:0] - 8'd1;
        end else begin
            d = s_c0 - tmin_reg;
        end
    end

    always_comb begin
        q_job.quant = quant;
        q_job.c0    = s_c0;
        q_job.c1    = s_c1;
        q_job.c2    = s_c2;
        q_job.d     = d;
        q_job.r     = rng;
        q_job.n     = tone_count[7:0];
        q_job.tmin  = tmin_reg;
    end

endmodule
`default_nettype wire

[hdl/gtq_queue.sv]
// Two-entry queue of classified map words between front and back.
`default_nettype none
module gtq_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire gtq_pkg::gtq_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output gtq_pkg::gtq_job_t      pop_job
);
    import gtq_pkg::*;

    gtq_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_job;
    end

    `include "gray_tone_quantizer_macros.svh"

    `GTQ_ASSERT(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
    `GTQ_ASSERT_IMP(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")

endmodule
`default_nettype wire

[hdl/gtq_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module gtq_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [gtq_pkg::DVD_W-1:0]     dividend,
    input  wire logic [gtq_pkg::DVS_W-1:0]     divisor,
    output logic                               done,
    output logic [gtq_pkg::DIV_STEPS-1:0]      quotient
);
    import gtq_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_STEPS-1:0] qd_reg;
    logic [DVS_W-1:0]     trial;
    logic                 ge;

    // The quotient fits DIV_STEPS bits, so the upper dividend bits already
    // form a partial remainder below the divisor.
    assign trial = {rem_reg[DVS_W-2:0], qd_reg[DIV_STEPS-1]};
    assign ge    = (trial >= dvs_reg);

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DVS_W'(dividend[DVD_W-1:DIV_STEPS]);
            qd_reg  <= dividend[DIV_STEPS-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? (trial - dvs_reg) : trial;
            qd_reg  <= {qd_reg[DIV_STEPS-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule
`default_nettype wire

[hdl/gtq_back.sv]
// Back end: requantizes map words with a shared multiplier and divider.
`default_nettype none
module gtq_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire gtq_pkg::gtq_job_t q_job,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata
);
    import gtq_pkg::*;

    gtq_back_state_t  state_reg, state_next;
    gtq_job_t         job_reg;
    logic [DVD_W-1:0] prod_reg;
    logic [7:0]       bin_reg;
    logic             out_valid_reg, out_valid_next;
    logic [23:0]      out_data_reg;

    logic             mul_sel2;
    logic [8:0]       mul_a;
    logic [8:0]       mul_b;
    logic [17:0]      mul_p;
    logic             div_start;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_STEPS-1:0] div_q;
    logic             load_out;
    logic [7:0]       tone_q;

    gtq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (q_valid) state_next = q_job.quant ? B_MUL1 : B_DONE;
            B_MUL1:   state_next = B_START1;
            B_START1: state_next = B_DIV1;
            B_DIV1:   if (div_done) state_next = B_MUL2;
            B_MUL2:   state_next = B_START2;
            B_START2: state_next = B_DIV2;
            B_DIV2:   if (div_done) state_next = B_DONE;
            B_DONE:   if (!out_valid_reg || m_tready) state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = (state_reg == B_IDLE) && q_valid;
        div_start = (state_reg == B_START1) || (state_reg == B_START2);
        mul_sel2  = (state_reg == B_MUL2);
        load_out  = (state_reg == B_DONE) && (!out_valid_reg || m_tready);
        // First division by 2r, second by 2n.
        div_divisor = (state_reg == B_START2) ? {1'b0, job_reg.n, 1'b0}
                                              : {job_reg.r, 1'b0};
    end

    // (2d+1)*n first, then (2*bin+1)*r.
    assign mul_a  = mul_sel2 ? {bin_reg, 1'b1} : {job_reg.d, 1'b1};
    assign mul_b  = mul_sel2 ? job_reg.r : {1'b0, job_reg.n};
    assign mul_p  = mul_a * mul_b;
    assign tone_q = job_reg.tmin + div_q[7:0];

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out)      out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) job_reg <= q_job;
        if ((state_reg == B_MUL1) || (state_reg == B_MUL2)) prod_reg <= mul_p[DVD_W-1:0];
        if ((state_reg == B_DIV1) && div_done) bin_reg <= div_q[7:0];
        if ((state_reg == B_DIV2) && div_done) begin
            job_reg.c0 <= tone_q;
            job_reg.c1 <= tone_q;
            job_reg.c2 <= tone_q;
        end
        if (load_out) out_data_reg <= {job_reg.c2, job_reg.c1, job_reg.c0};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `include "gray_tone_quantizer_macros.svh"

    `GTQ_ASSERT_IMP(a_div_done_state, div_done,
        (state_reg == B_DIV1) || (state_reg == B_DIV2), "divider result outside a wait state")
    `GTQ_ASSERT_NXT(a_done_loads, (state_reg == B_DONE) && !out_valid_reg,
        out_valid_reg && (state_reg == B_IDLE), "finished word not moved to output")

endmodule
`default_nettype wire

[hdl/gray_tone_quantizer.sv]
// Top level of the gray tone quantizer: ports, tone count register, wiring.
//
// Use: software streams a frame twice on the s_ channel. s_tuser carries the
// operation: clear resets the tone range, scan widens it with the gray level
// in s_tdata[7:0], map requantizes one pixel and yields one result word on
// the m_ channel. Clear, scan and unused codes yield no result.
// tone_count is written over the APB port at byte address 0 while idle; it
// resets to 256, which lets every pixel pass unchanged.
// Throughput: clear and scan words are taken one per cycle while the queue
// has room. A passed map word occupies the back end for the pop and the
// output load; a requantized one for the pop, then twice a multiply, a
// divider start and a divider wait (nine quotient steps and a done step),
// then the output load. From the accepting edge a pixel passes the queue,
// these back end steps and the output register before m_tvalid rises.
// A two-word queue sits between the classifying front end and the back end,
// and the result sits in an output register, so the front keeps accepting
// while a result waits on m_tready. When the queue is full s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and output register and
// restores the empty range and the tone count of 256.
`default_nettype none
module gray_tone_quantizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input words.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // chan0 [7:0], chan1 [15:8], chan2 [23:16]
    input  wire logic [1:0]  s_tuser,   // op [1:0]
    // Result words.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out0 [7:0], out1 [15:8], out2 [23:16]
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import gtq_pkg::*;

    logic [8:0] tone_count_reg, tone_count_next;
    logic       cfg_write;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    gtq_job_t   push_job;
    gtq_job_t   pop_job;

    // The port never waits; registers are word aligned, so paddr[2] picks one.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        tone_count_next = tone_count_reg;
        if (cfg_write && (paddr[2] == REG_TONE_COUNT)) tone_count_next = pwdata[8:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_count_reg <= TONE_COUNT_RESET;
        end else begin
            tone_count_reg <= tone_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_TONE_COUNT) ? {23'd0, tone_count_reg} : 32'd0;

    // The front end snapshots the range and tone count with each map word,
    // so later scans cannot disturb words already queued.
    gtq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_op       (s_tuser),
        .s_c0       (s_tdata[7:0]),
        .s_c1       (s_tdata[15:8]),
        .s_c2       (s_tdata[23:16]),
        .s_ready    (s_tready),
        .tone_count (tone_count_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    gtq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_job   (pop_job)
    );

    gtq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
